@@ sv/irhc_pkg.sv @@
package irhc_pkg;

    localparam int unsigned WordW  = 16;
    localparam int unsigned IndexW = 6;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_VERSION  = 4'd2;
    localparam logic [3:0] ST_HDRLEN   = 4'd3;
    localparam logic [3:0] ST_TOTLEN   = 4'd4;
    localparam logic [3:0] ST_PROTO    = 4'd5;
    localparam logic [3:0] ST_SOURCE   = 4'd6;
    localparam logic [3:0] ST_OFFSET   = 4'd7;
    localparam logic [3:0] ST_OVERLIM  = 4'd8;
    localparam logic [3:0] ST_CHECKSUM = 4'd9;

    localparam logic [IndexW-1:0] WIDX_FIRST  = 6'd0;
    localparam logic [IndexW-1:0] WIDX_TOTLEN = 6'd1;
    localparam logic [IndexW-1:0] WIDX_FRAG   = 6'd3;
    localparam logic [IndexW-1:0] WIDX_PROTO  = 6'd4;
    localparam logic [IndexW-1:0] WIDX_SRC_HI = 6'd6;
    localparam logic [IndexW-1:0] WIDX_SRC_LO = 6'd7;
    localparam logic [IndexW-1:0] WIDX_MAX    = 6'd63;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  IP_VERSION4   = 4'd4;

    localparam logic [7:0] PROTO_HOPOPT = 8'd0;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    localparam logic [3:0]  MCAST_PREFIX = 4'he;
    localparam logic [12:0] OFFSET_MAX   = 13'h1fff;

    typedef struct packed {
        logic [WordW-1:0] header_word;
        logic             first_word;
        logic             last_word;
        logic [15:0]      segment_bytes;
        logic [15:0]      packet_bytes;
        logic             offload_sum_good;
        logic             offload_sum_bad;
    } t_irhc_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] trim_bytes;
        logic [7:0]  protocol;
        logic [5:0]  header_bytes;
    } t_irhc_rslt;

endpackage

@@ sv/ipv4_rx_header_checker_core.sv @@
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------
// input    | i_in_valid  | o_in_stall  | i_in_req   (t_irhc_req)
// output   | o_out_valid | i_out_stall | o_out_rslt (t_irhc_rslt)
//
// One header word per cycle while o_in_stall is low. A word is registered on
// acceptance and then folded into the header state; a last word's verdict
// lands in the result register in that same cycle, and the state is cleared.
// Reset (synchronous, active low) clears the header state and both valids.
// A stalled result blocks only a later last word; other words keep flowing.
module ipv4_rx_header_checker_core
    import irhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_irhc_req  i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_irhc_rslt o_out_rslt
);

    logic        r_s1_valid;
    t_irhc_req   r_s1;
    logic        r_out_valid;
    t_irhc_rslt  r_out;

    logic [IndexW-1:0] r_widx;
    logic [15:0]       r_sum;
    logic [7:0]        r_vihl;
    logic [15:0]       r_tot;
    logic [15:0]       r_frag;
    logic [7:0]        r_proto;
    logic [31:0]       r_src;
    logic [15:0]       r_seg;
    logic [15:0]       r_pkt;
    logic              r_ol_good;
    logic              r_ol_bad;

    logic [IndexW-1:0] b_widx;
    logic [15:0]       b_sum;
    logic [7:0]        b_vihl;
    logic [15:0]       b_tot;
    logic [15:0]       b_frag;
    logic [7:0]        b_proto;
    logic [31:0]       b_src;

    logic [IndexW-1:0] n_widx;
    logic [15:0]       n_sum;
    logic [7:0]        n_vihl;
    logic [15:0]       n_tot;
    logic [15:0]       n_frag;
    logic [7:0]        n_proto;
    logic [31:0]       n_src;
    logic [15:0]       n_seg;
    logic [15:0]       n_pkt;
    logic              n_ol_good;
    logic              n_ol_bad;

    logic [IndexW-1:0] covered;
    logic [16:0]       sum_raw;
    logic [15:0]       sum_fold;
    logic [15:0]       hdr16;
    logic [16:0]       end_sum;
    logic              src_bad;
    logic              proto_ok;
    t_irhc_rslt        n_rslt;

    logic out_free;
    logic s1_adv;
    logic in_acc;
    logic s1_done;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!r_s1.last_word || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign s1_done    = s1_adv && r_s1.last_word;

    always_comb begin
        b_widx    = r_widx;
        b_sum     = r_sum;
        b_vihl    = r_vihl;
        b_tot     = r_tot;
        b_frag    = r_frag;
        b_proto   = r_proto;
        b_src     = r_src;
        n_seg     = r_seg;
        n_pkt     = r_pkt;
        n_ol_good = r_ol_good;
        n_ol_bad  = r_ol_bad;
        if (r_s1.first_word) begin
            b_widx    = '0;
            b_sum     = '0;
            b_vihl    = '0;
            b_tot     = '0;
            b_frag    = '0;
            b_proto   = '0;
            b_src     = '0;
            n_seg     = r_s1.segment_bytes;
            n_pkt     = r_s1.packet_bytes;
            n_ol_good = r_s1.offload_sum_good;
            n_ol_bad  = r_s1.offload_sum_bad;
        end

        n_vihl   = (b_widx == WIDX_FIRST) ? r_s1.header_word[15:8] : b_vihl;
        covered  = {1'b0, n_vihl[3:0], 1'b0};
        sum_raw  = {1'b0, b_sum} + {1'b0, r_s1.header_word};
        sum_fold = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];

        n_sum   = b_sum;
        n_tot   = b_tot;
        n_frag  = b_frag;
        n_proto = b_proto;
        n_src   = b_src;
        if (b_widx < covered) begin
            n_sum = sum_fold;
            case (b_widx)
                WIDX_TOTLEN: n_tot   = r_s1.header_word;
                WIDX_FRAG:   n_frag  = r_s1.header_word;
                WIDX_PROTO:  n_proto = r_s1.header_word[7:0];
                WIDX_SRC_HI: n_src   = {r_s1.header_word, b_src[15:0]};
                WIDX_SRC_LO: n_src   = {b_src[31:16], r_s1.header_word};
                default:     n_src   = b_src;
            endcase
        end
        n_widx = (b_widx == WIDX_MAX) ? b_widx : b_widx + 6'd1;
    end

    // verdict, first failing check wins
    always_comb begin
        hdr16    = {10'd0, n_vihl[3:0], 2'b00};
        end_sum  = {1'b0, n_frag[12:0], 3'b000} + {1'b0, n_tot};
        src_bad  = (n_src == 32'd0) || (n_src == 32'hffff_ffff)
                   || (n_src[31:28] == MCAST_PREFIX);
        proto_ok = (n_proto == PROTO_HOPOPT) || (n_proto == PROTO_ICMP)
                   || (n_proto == PROTO_TCP) || (n_proto == PROTO_UDP);

        n_rslt.protocol     = n_proto;
        n_rslt.header_bytes = hdr16[5:0];
        n_rslt.trim_bytes   = '0;
        n_rslt.status       = ST_OK;
        if (n_seg < MIN_HDR_BYTES) begin
            n_rslt.status = ST_SHORT;
        end else if (n_vihl[7:4] != IP_VERSION4) begin
            n_rslt.status = ST_VERSION;
        end else if (hdr16 > n_seg || hdr16 < MIN_HDR_BYTES || n_pkt == hdr16) begin
            n_rslt.status = ST_HDRLEN;
        end else if (n_tot <= hdr16 || n_tot > n_pkt) begin
            n_rslt.status = ST_TOTLEN;
        end else begin
            n_rslt.trim_bytes = n_pkt - n_tot;
            if (!proto_ok) begin
                n_rslt.status = ST_PROTO;
            end else if (src_bad) begin
                n_rslt.status = ST_SOURCE;
            end else if (n_frag[13] && n_frag[12:0] == OFFSET_MAX) begin
                n_rslt.status = ST_OFFSET;
            end else if (end_sum[16]) begin
                n_rslt.status = ST_OVERLIM;
            end else if (n_ol_good) begin
                n_rslt.status = ST_OK;
            end else if (n_ol_bad || n_sum != 16'hffff) begin
                n_rslt.status = ST_CHECKSUM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_out <= n_rslt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s1_done) begin
            r_widx    <= '0;
            r_sum     <= '0;
            r_vihl    <= '0;
            r_tot     <= '0;
            r_frag    <= '0;
            r_proto   <= '0;
            r_src     <= '0;
            r_seg     <= '0;
            r_pkt     <= '0;
            r_ol_good <= 1'b0;
            r_ol_bad  <= 1'b0;
        end else if (s1_adv) begin
            r_widx    <= n_widx;
            r_sum     <= n_sum;
            r_vihl    <= n_vihl;
            r_tot     <= n_tot;
            r_frag    <= n_frag;
            r_proto   <= n_proto;
            r_src     <= n_src;
            r_seg     <= n_seg;
            r_pkt     <= n_pkt;
            r_ol_good <= n_ol_good;
            r_ol_bad  <= n_ol_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rslt  = r_out;

    a_verdict_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done |=> (o_out_valid && r_widx == '0 && r_sum == '0))
        else $error("verdict not registered or header state not cleared");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !s1_done)
        else $error("pending result overwritten");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rslt.status <= ST_CHECKSUM))
        else $error("status code out of range");

    a_trim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rslt.status >= ST_SHORT && o_out_rslt.status <= ST_TOTLEN)
        |-> (o_out_rslt.trim_bytes == '0))
        else $error("trim given for a length failure");

endmodule

@@ bench/irhc_verdict_checker.sv @@
`timescale 1ns / 100ps
module irhc_verdict_checker
    import irhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_irhc_req  i_in_req,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_irhc_rslt i_out_rslt,
    output int         o_fail_count,
    output int         o_pending
);

    logic [IndexW-1:0] word_pos;
    logic [16:0]       csum;
    logic [7:0]        ver_ihl;
    logic [15:0]       tot_len;
    logic [15:0]       frag;
    logic [7:0]        proto;
    logic [31:0]       src_addr;
    logic [15:0]       seg_bytes;
    logic [15:0]       pkt_bytes;
    logic              ol_good;
    logic              ol_bad;
    t_irhc_rslt        verdicts_due[$];

    task automatic clear_header();
        word_pos  = '0;
        csum      = '0;
        ver_ihl   = '0;
        tot_len   = '0;
        frag      = '0;
        proto     = '0;
        src_addr  = '0;
        seg_bytes = '0;
        pkt_bytes = '0;
        ol_good   = 1'b0;
        ol_bad    = 1'b0;
    endtask

    function automatic logic [16:0] fold_add(logic [16:0] acc, logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc[15:0]} + {1'b0, w};
        if (s[16]) begin
            s = {1'b0, s[15:0]} + 17'd1;
        end
        return s;
    endfunction

    function automatic logic src_rejected(logic [31:0] a);
        return (a == '0) || (a == '1) || (a[31:28] == MCAST_PREFIX);
    endfunction

    function automatic logic proto_known(logic [7:0] p);
        return (p == PROTO_HOPOPT) || (p == PROTO_ICMP) || (p == PROTO_TCP) ||
               (p == PROTO_UDP);
    endfunction

    // fold one header word into the state; on a last word queue the verdict
    task automatic take_word(input t_irhc_req r);
        logic [IndexW-1:0] covered;
        logic [12:0]       off;
        int                hdr;
        int                seg;
        int                pkt;
        int                tot;
        t_irhc_rslt        v;
        if (r.first_word) begin
            clear_header();
            seg_bytes = r.segment_bytes;
            pkt_bytes = r.packet_bytes;
            ol_good   = r.offload_sum_good;
            ol_bad    = r.offload_sum_bad;
        end
        if (word_pos == WIDX_FIRST) begin
            ver_ihl = r.header_word[15:8];
        end
        covered = {1'b0, ver_ihl[3:0], 1'b0};
        if (word_pos < covered) begin
            csum = fold_add(csum, r.header_word);
            case (word_pos)
                WIDX_TOTLEN: tot_len = r.header_word;
                WIDX_FRAG:   frag = r.header_word;
                WIDX_PROTO:  proto = r.header_word[7:0];
                WIDX_SRC_HI: src_addr[31:16] = r.header_word;
                WIDX_SRC_LO: src_addr[15:0] = r.header_word;
                default: ;
            endcase
        end
        if (word_pos < WIDX_MAX) begin
            word_pos = word_pos + 6'd1;
        end
        if (r.last_word) begin
            hdr = int'(ver_ihl[3:0]) * 4;
            seg = int'(seg_bytes);
            pkt = int'(pkt_bytes);
            tot = int'(tot_len);
            off = frag[12:0];
            v = '0;
            v.status = ST_OK;
            if (seg < int'(MIN_HDR_BYTES)) begin
                v.status = ST_SHORT;
            end else if (ver_ihl[7:4] != IP_VERSION4) begin
                v.status = ST_VERSION;
            end else if (hdr > seg || hdr < int'(MIN_HDR_BYTES) || pkt == hdr) begin
                v.status = ST_HDRLEN;
            end else if (tot <= hdr || tot > pkt) begin
                v.status = ST_TOTLEN;
            end else begin
                v.trim_bytes = 16'(pkt - tot);
                if (!proto_known(proto)) begin
                    v.status = ST_PROTO;
                end else if (src_rejected(src_addr)) begin
                    v.status = ST_SOURCE;
                end else if (frag[13] && off == OFFSET_MAX) begin
                    v.status = ST_OFFSET;
                end else if (int'(off) * 8 + tot > 65535) begin
                    v.status = ST_OVERLIM;
                end else if (ol_good) begin
                    v.status = ST_OK;
                end else if (ol_bad || csum[15:0] != 16'hffff) begin
                    v.status = ST_CHECKSUM;
                end
            end
            v.protocol     = proto;
            v.header_bytes = 6'(hdr);
            verdicts_due.push_back(v);
            clear_header();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_irhc_rslt want;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_header();
            verdicts_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                take_word(i_in_req);
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: verdict with none expected, got status %0d trim %0d",
                             $time, i_out_rslt.status, i_out_rslt.trim_bytes);
                    errs++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_out_rslt.status != want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_out_rslt.status);
                        errs++;
                    end
                    if (i_out_rslt.trim_bytes != want.trim_bytes) begin
                        $display("%0t: trim_bytes expected %0d got %0d",
                                 $time, want.trim_bytes, i_out_rslt.trim_bytes);
                        errs++;
                    end
                    if (i_out_rslt.protocol != want.protocol) begin
                        $display("%0t: protocol expected %0d got %0d",
                                 $time, want.protocol, i_out_rslt.protocol);
                        errs++;
                    end
                    if (i_out_rslt.header_bytes != want.header_bytes) begin
                        $display("%0t: header_bytes expected %0d got %0d",
                                 $time, want.header_bytes, i_out_rslt.header_bytes);
                        errs++;
                    end
                end
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= verdicts_due.size();
    end

endmodule

@@ bench/tb_ipv4_rx_header_checker_core.sv @@
`timescale 1ns / 100ps
module tb_ipv4_rx_header_checker_core;
    import irhc_pkg::*;

    typedef enum int {
        HC_CLEAN,
        HC_SHORT_SEG,
        HC_BAD_VERSION,
        HC_IHL_LOW,
        HC_HDR_OVER_SEG,
        HC_PKT_EQ_HDR,
        HC_TOT_LOW,
        HC_TOT_HIGH,
        HC_BAD_PROTO,
        HC_SRC_ZERO,
        HC_SRC_BCAST,
        HC_SRC_MCAST,
        HC_MF_MAX_OFF,
        HC_OVER_LIMIT,
        HC_BAD_SUM,
        HC_OFFLOAD_GOOD,
        HC_OFFLOAD_BAD,
        HC_OFFLOAD_BOTH,
        HC_CUT_SHORT,
        HC_PAST_IHL,
        HC_NO_START,
        HC_NOISE,
        HC_LONG
    } hdr_case_e;

    localparam int PhaseWords = 60;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_irhc_req  i_in_req    = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_irhc_rslt o_out_rslt;
    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         words_sent    = 0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    ipv4_rx_header_checker_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rslt  (o_out_rslt)
    );

    irhc_verdict_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_rslt   (o_out_rslt),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_word(input t_irhc_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // hold off until every verdict is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_header(input hdr_case_e hc);
        logic [15:0] hw [0:79];
        logic [3:0]  ver;
        logic [31:0] src;
        logic [31:0] sum32;
        logic [16:0] s;
        logic [7:0]  proto;
        logic        mf;
        logic        good;
        logic        bad;
        logic        start;
        int          ihl;
        int          tot;
        int          pkt;
        int          seg;
        int          off;
        int          n;
        int          i;
        t_irhc_req   r;
        ihl = ($urandom_range(3) == 0 || hc == HC_HDR_OVER_SEG) ? $urandom_range(15, 6) : 5;
        ver = IP_VERSION4;
        if ($urandom_range(3) == 0) begin
            tot = $urandom_range(65535, ihl * 4 + 1);
        end else begin
            tot = $urandom_range(ihl * 4 + 300, ihl * 4 + 1);
        end
        pkt = tot + $urandom_range(64);
        if (pkt > 65535) begin
            pkt = 65535;
        end
        seg = $urandom_range(pkt, ihl * 4);
        case ($urandom_range(3))
            0:       proto = PROTO_HOPOPT;
            1:       proto = PROTO_ICMP;
            2:       proto = PROTO_TCP;
            default: proto = PROTO_UDP;
        endcase
        do begin
            src = $urandom;
        end while (src == '0 || src == '1 || src[31:28] == MCAST_PREFIX);
        mf    = 1'($urandom);
        off   = ($urandom_range(1) == 0) ? 0 : $urandom_range((65535 - tot) / 8);
        good  = 1'b0;
        bad   = 1'b0;
        start = 1'b1;
        case (hc)
            HC_SHORT_SEG: seg = $urandom_range(19);
            HC_BAD_VERSION: begin
                do begin
                    ver = 4'($urandom);
                end while (ver == IP_VERSION4);
            end
            HC_IHL_LOW:      ihl = $urandom_range(4);
            HC_HDR_OVER_SEG: seg = $urandom_range(ihl * 4 - 1, 20);
            HC_PKT_EQ_HDR: begin
                pkt = ihl * 4;
                seg = pkt;
            end
            HC_TOT_LOW: tot = $urandom_range(ihl * 4);
            HC_TOT_HIGH: begin
                pkt = $urandom_range(65534, ihl * 4 + 1);
                tot = $urandom_range(65535, pkt + 1);
                seg = $urandom_range(pkt, ihl * 4);
            end
            HC_BAD_PROTO: begin
                do begin
                    proto = 8'($urandom);
                end while (proto == PROTO_HOPOPT || proto == PROTO_ICMP ||
                           proto == PROTO_TCP || proto == PROTO_UDP);
            end
            HC_SRC_ZERO:  src = '0;
            HC_SRC_BCAST: src = '1;
            HC_SRC_MCAST: src = {MCAST_PREFIX, 28'($urandom)};
            HC_MF_MAX_OFF: begin
                mf  = 1'b1;
                off = int'(OFFSET_MAX);
            end
            HC_OVER_LIMIT: begin
                off = $urandom_range(8191, (65536 - tot + 7) / 8);
                if (off == int'(OFFSET_MAX)) begin
                    mf = 1'b0;
                end
            end
            HC_OFFLOAD_GOOD: good = 1'b1;
            HC_OFFLOAD_BAD:  bad = 1'b1;
            HC_OFFLOAD_BOTH: begin
                good = 1'b1;
                bad  = 1'b1;
            end
            HC_NO_START: start = 1'b0;
            default: ;
        endcase
        hw[0] = {ver, 4'(ihl), 8'($urandom)};
        hw[1] = 16'(tot);
        hw[2] = 16'($urandom);
        hw[3] = {1'($urandom), 1'($urandom), mf, 13'(off)};
        hw[4] = {8'($urandom), proto};
        hw[5] = '0;
        hw[6] = src[31:16];
        hw[7] = src[15:0];
        for (i = 8; i < 80; i++) begin
            hw[i] = 16'($urandom);
        end
        sum32 = '0;
        for (i = 0; i < ihl * 2; i++) begin
            sum32 = sum32 + 32'(hw[i]);
        end
        s = {1'b0, sum32[15:0]} + {1'b0, sum32[31:16]};
        s = {1'b0, s[15:0]} + 17'(s[16]);
        hw[5] = ~s[15:0];
        if (hc == HC_BAD_SUM || hc == HC_OFFLOAD_GOOD || hc == HC_OFFLOAD_BOTH) begin
            hw[5] = hw[5] ^ (16'd1 << $urandom_range(15));
        end
        case (hc)
            HC_IHL_LOW:   n = 10;
            HC_CUT_SHORT: n = $urandom_range(ihl * 2 - 1, 1);
            HC_PAST_IHL:  n = ihl * 2 + $urandom_range(6, 1);
            HC_NOISE:     n = $urandom_range(12, 1);
            HC_LONG:      n = $urandom_range(70, 64);
            default:      n = ihl * 2;
        endcase
        for (i = 0; i < n; i++) begin
            r.segment_bytes    = 16'($urandom);
            r.packet_bytes     = 16'($urandom);
            r.offload_sum_good = 1'($urandom);
            r.offload_sum_bad  = 1'($urandom);
            r.header_word      = (hc == HC_NOISE) ? 16'($urandom) : hw[i];
            r.first_word       = (hc == HC_NOISE) ? 1'($urandom) : (i == 0 && start);
            r.last_word        = (i == n - 1) || (hc == HC_NOISE && $urandom_range(5) == 0);
            if (r.first_word && hc != HC_NOISE) begin
                r.segment_bytes    = 16'(seg);
                r.packet_bytes     = 16'(pkt);
                r.offload_sum_good = good;
                r.offload_sum_bad  = bad;
            end
            send_word(r);
        end
    endtask

    initial begin
        int        hc_i;
        int        phase;
        int        base;
        hdr_case_e hc;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 21;
        stall_pct     = 55;
        for (hc_i = HC_CLEAN; hc_i <= HC_LONG; hc_i++) begin
            send_header(hdr_case_e'(hc_i));
        end
        base = words_sent;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    stall_pct     = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    stall_pct     = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            while (words_sent < base + PhaseWords * (phase + 1)) begin
                if ($urandom_range(99) < 45) begin
                    hc = HC_CLEAN;
                end else begin
                    hc = hdr_case_e'($urandom_range(HC_NOISE, HC_SHORT_SEG));
                end
                send_header(hc);
            end
            drain();
        end
        if (fail_count == 0 && pending == 0) begin
            $display("[ipv4_rx_header_checker_core] OK");
        end else begin
            $display("[ipv4_rx_header_checker_core] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[ipv4_rx_header_checker_core] ERROR");
        $finish;
    end

endmodule
